>>> rtl/bsa_pkg.sv
`timescale 1ns / 1ps

package bsa_pkg;

  localparam int CMD_W   = 2;
  localparam int SLOT_W  = 10;
  localparam int COUNT_W = 11;
  localparam int HINT_W  = 11;
  localparam int CFG_W   = 8;
  localparam int WORD_W  = 32;
  localparam int OFF_W   = 5;
  localparam int BYTE_SHIFT = 3;
  localparam int LIM_MAX = 2040;

  localparam logic [CFG_W-1:0] CFG_RESET = 8'd128;

  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MARK  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ALREADY = 2'd1,
    ST_RANGE   = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CHECK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic rd;
    logic chk;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic need_scan;
    logic more;
  } dp_stat_t;

endpackage

>>> rtl/bsa_if.sv
`timescale 1ns / 1ps

interface bsa_in_if import bsa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [SLOT_W-1:0] position;

  modport source (output valid, command, position, input ready);
  modport sink   (input valid, command, position, output ready);
endinterface

interface bsa_out_if import bsa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [SLOT_W-1:0]  slot;
  logic [COUNT_W-1:0] used_count;

  modport source (output valid, status, slot, used_count, input ready);
  modport sink   (input valid, status, slot, used_count, output ready);
endinterface

>>> rtl/bsa_ram.sv
`timescale 1ns / 1ps

module bsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/bsa_ctrl.sv
`timescale 1ns / 1ps

module bsa_ctrl import bsa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    cmd           = '0;
    in_ready      = 1'b0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = stat.need_scan ? S_READ : S_DONE;
        end
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.chk   = 1'b1;
        state_nxt = stat.more ? S_READ : S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

>>> rtl/bsa_datapath.sv
`timescale 1ns / 1ps

module bsa_datapath import bsa_pkg::*; #(
  parameter int MAX_SLOTS = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CFG_W-1:0]   cfg_wdata,
  input  logic [CMD_W-1:0]   in_command,
  input  logic [SLOT_W-1:0]  in_position,
  input  ctrl_cmd_t          cmd,
  output dp_stat_t           stat,
  output logic [1:0]         out_status,
  output logic [SLOT_W-1:0]  out_slot,
  output logic [COUNT_W-1:0] out_used_count
);

  localparam int WORDS = (MAX_SLOTS + WORD_W - 1) / WORD_W;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int CAP   = (MAX_SLOTS < LIM_MAX) ? MAX_SLOTS : LIM_MAX;
  localparam int IDX_W = HINT_W - OFF_W;

  logic [CFG_W-1:0]   bytes_r;
  logic [HINT_W-1:0]  hint_r, hint_nxt;
  logic [COUNT_W-1:0] used_r, used_nxt;
  logic [AW-1:0]      clr_r;

  logic [CMD_W-1:0]   cmd_r, cmd_nxt;
  logic [HINT_W-1:0]  scan_r, scan_nxt;
  logic               phase_r, phase_nxt;
  status_t            st_r, st_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;

  logic [1:0]         out_status_r;
  logic [SLOT_W-1:0]  out_slot_r;
  logic [COUNT_W-1:0] out_used_r;

  logic [HINT_W-1:0]  lim_raw, lim;
  logic [OFF_W-1:0]   off;
  logic [WORD_W-1:0]  rdata, mask, free_vec, onehot_off, onehot_idx;
  logic [OFF_W-1:0]   idx;
  logic               any_free, bit_off, nb_end;
  logic [HINT_W-1:0]  found, found_p1;
  logic [HINT_W:0]    nb;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [WORD_W-1:0]  ram_wdata;

  assign lim_raw = {bytes_r, BYTE_SHIFT'(0)};
  assign lim     = (lim_raw > HINT_W'(CAP)) ? HINT_W'(CAP) : lim_raw;

  assign off        = scan_r[OFF_W-1:0];
  assign ram_raddr  = AW'(scan_r[HINT_W-1:OFF_W]);
  assign bit_off    = rdata[off];
  assign onehot_off = WORD_W'(1) << off;
  assign onehot_idx = WORD_W'(1) << idx;
  assign found      = {scan_r[HINT_W-1:OFF_W], idx};
  assign found_p1   = found + HINT_W'(1);
  assign nb         = {({1'b0, scan_r[HINT_W-1:OFF_W]} + (IDX_W + 1)'(1)), OFF_W'(0)};
  assign nb_end     = nb >= {1'b0, lim};

  // usable free bits of the current word, from the scan offset up to the limit
  always_comb begin
    for (int i = 0; i < WORD_W; i++) begin
      mask[i] = (OFF_W'(i) >= off) &&
                ({scan_r[HINT_W-1:OFF_W], OFF_W'(i)} < lim);
    end
    free_vec = ~rdata & mask;
    any_free = |free_vec;
    idx      = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        idx = OFF_W'(i);
      end
    end
  end

  always_comb begin
    hint_nxt        = hint_r;
    used_nxt        = used_r;
    cmd_nxt         = cmd_r;
    scan_nxt        = scan_r;
    phase_nxt       = phase_r;
    st_nxt          = st_r;
    slot_nxt        = slot_r;
    ram_we          = 1'b0;
    ram_waddr       = ram_raddr;
    ram_wdata       = '0;
    stat.need_scan  = 1'b0;
    stat.more       = 1'b0;
    stat.clear_last = (clr_r == AW'(WORDS - 1));

    if (cmd.clear) begin
      ram_we    = 1'b1;
      ram_waddr = clr_r;
    end

    if (cmd.load) begin
      cmd_nxt   = in_command;
      phase_nxt = 1'b0;
      slot_nxt  = in_position;
      st_nxt    = ST_RANGE;
      case (in_command)
        CMD_ALLOC: begin
          if (hint_r >= lim) begin
            st_nxt   = ST_FULL;
            slot_nxt = '0;
          end else begin
            stat.need_scan = 1'b1;
            scan_nxt       = hint_r;
          end
        end
        CMD_MARK, CMD_FREE: begin
          if ({1'b0, in_position} < lim) begin
            stat.need_scan = 1'b1;
            scan_nxt       = {1'b0, in_position};
          end
        end
        default: begin
        end
      endcase
    end

    if (cmd.chk) begin
      case (cmd_r)
        CMD_ALLOC: begin
          if (!phase_r) begin
            if (any_free) begin
              ram_we    = 1'b1;
              ram_wdata = rdata | onehot_idx;
              used_nxt  = used_r + COUNT_W'(1);
              st_nxt    = ST_OK;
              slot_nxt  = SLOT_W'(found);
              if (found_p1 >= lim) begin
                hint_nxt = lim;
              end else begin
                scan_nxt  = found_p1;
                phase_nxt = 1'b1;
                stat.more = 1'b1;
              end
            end else if (nb_end) begin
              st_nxt   = ST_FULL;
              slot_nxt = '0;
            end else begin
              scan_nxt  = nb[HINT_W-1:0];
              stat.more = 1'b1;
            end
          end else begin
            if (any_free) begin
              hint_nxt = found;
            end else if (nb_end) begin
              hint_nxt = lim;
            end else begin
              scan_nxt  = nb[HINT_W-1:0];
              stat.more = 1'b1;
            end
          end
        end
        CMD_MARK: begin
          if (bit_off) begin
            st_nxt = ST_ALREADY;
          end else begin
            ram_we    = 1'b1;
            ram_wdata = rdata | onehot_off;
            used_nxt  = used_r + COUNT_W'(1);
            st_nxt    = ST_OK;
          end
        end
        CMD_FREE: begin
          if (!bit_off) begin
            st_nxt = ST_ALREADY;
          end else begin
            ram_we    = 1'b1;
            ram_wdata = rdata & ~onehot_off;
            used_nxt  = used_r - COUNT_W'(1);
            st_nxt    = ST_OK;
            if (scan_r < hint_r) begin
              hint_nxt = scan_r;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_r <= CFG_RESET;
      hint_r  <= '0;
      used_r  <= '0;
      clr_r   <= '0;
    end else begin
      if (cfg_we) begin
        bytes_r <= cfg_wdata;
      end
      hint_r <= hint_nxt;
      used_r <= used_nxt;
      if (cmd.clear) begin
        clr_r <= clr_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    scan_r  <= scan_nxt;
    phase_r <= phase_nxt;
    st_r    <= st_nxt;
    slot_r  <= slot_nxt;
    if (cmd.out_load) begin
      out_status_r <= st_r;
      out_slot_r   <= slot_r;
      out_used_r   <= used_r;
    end
  end

  bsa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WORDS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  assign out_status     = out_status_r;
  assign out_slot       = out_slot_r;
  assign out_used_count = out_used_r;

endmodule

>>> rtl/bitmap_slot_allocator.sv
`timescale 1ns / 1ps
// bitmap slot allocator, lowest free slot first
// in_ch carries a command (allocate, mark, free) and a slot position; out_ch
// returns one result per command: status, slot and the used-slot count after it.
// cfg_we/cfg_wdata write the active byte count; slots in use are 8 per byte,
// capped at MAX_SLOTS. write it only while no command is in flight.
// the bitmap sits in a RAM of 32-bit words with a registered read port.
// from transfer in to the result: mark and free read the bitmap word, then
// check/write it; commands that fail up front go straight to the result. allocate
// reads and checks each bitmap word visited (one read, one check/write): the word
// holding the hint through the word holding the allocated slot, then on to the
// next free slot for the new hint. one command is in work at a time; the next
// is taken once the current result is in the output register.
// reset: the bitmap is cleared one word a cycle, all MAX_SLOTS / 32 words (rounded
// up), with in_ch.ready low; count and hint go to zero, active bytes to 128.
// a stalled receiver holds the result in the output register; one more command
// can be taken and worked, then it waits until the held result is transferred.
module bitmap_slot_allocator import bsa_pkg::*; #(
  parameter int MAX_SLOTS = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  bsa_in_if.sink           in_ch,
  bsa_out_if.source        out_ch
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  bsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bsa_datapath #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_command     (in_ch.command),
    .in_position    (in_ch.position),
    .cmd            (cmd),
    .stat           (stat),
    .out_status     (out_ch.status),
    .out_slot       (out_ch.slot),
    .out_used_count (out_ch.used_count)
  );

endmodule

>>> rtl/bsa_checker.sv
`timescale 1ns / 1ps

module bsa_checker import bsa_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         out_status,
  input logic [SLOT_W-1:0]  out_slot,
  input logic [COUNT_W-1:0] out_used_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(out_status) && $stable(out_slot) && $stable(out_used_count))
    else $error("result changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("handshake active right after reset");

  a_full_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |-> (out_slot == '0))
    else $error("full result with nonzero slot");

endmodule

bind bitmap_slot_allocator bsa_checker u_bsa_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_status     (out_ch.status),
  .out_slot       (out_ch.slot),
  .out_used_count (out_ch.used_count)
);

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench import bsa_pkg::*; ();

  localparam int NUM_SLOTS = 1024;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int NUM_PHASES = 9;

  typedef struct packed {
    status_t            status;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] used_count;
  } slot_result_t;

  typedef struct packed {
    logic               cfg_row;
    logic [CFG_W-1:0]   cfg_value;
    logic [CMD_W-1:0]   cmd;
    logic [SLOT_W-1:0]  pos;
    logic               typed;
    slot_result_t       result;
  } vector_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  bsa_in_if  in_ch ();
  bsa_out_if out_ch ();

  bitmap_slot_allocator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // allocator state as predicted
  bit [NUM_SLOTS-1:0] taken_map;
  int                 taken_total;
  int                 lowest_free;
  logic [CFG_W-1:0]   active_bytes_q;

  slot_result_t pending_results [$];
  int           errors;
  int           in_idle_pct;
  int           out_idle_pct;
  vector_t      directed_rows [27];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("simulation failed");
    $finish;
  end

  function automatic int current_limit();
    int lim;
    lim = int'(active_bytes_q) * 8;
    if (lim > NUM_SLOTS) lim = NUM_SLOTS;
    return lim;
  endfunction

  function automatic int first_free(input int from, input int lim);
    for (int p = from; p < lim; p++) begin
      if (!taken_map[p]) return p;
    end
    return lim;
  endfunction

  function automatic slot_result_t apply_command(input logic [CMD_W-1:0] cmd,
                                                 input logic [SLOT_W-1:0] pos);
    slot_result_t r;
    int lim;
    int found;
    lim = current_limit();
    r.status = ST_RANGE;
    r.slot = pos;
    case (cmd)
      CMD_ALLOC: begin
        found = first_free(lowest_free, lim);
        if (found >= lim) begin
          r.status = ST_FULL;
          r.slot = '0;
        end else begin
          taken_map[found] = 1'b1;
          taken_total++;
          lowest_free = first_free(found + 1, lim);
          r.status = ST_OK;
          r.slot = SLOT_W'(found);
        end
      end
      CMD_MARK: begin
        if (int'(pos) < lim) begin
          if (taken_map[pos]) begin
            r.status = ST_ALREADY;
          end else begin
            taken_map[pos] = 1'b1;
            taken_total++;
            r.status = ST_OK;
          end
        end
      end
      CMD_FREE: begin
        if (int'(pos) < lim) begin
          if (!taken_map[pos]) begin
            r.status = ST_ALREADY;
          end else begin
            taken_map[pos] = 1'b0;
            taken_total--;
            if (int'(pos) < lowest_free) lowest_free = int'(pos);
            r.status = ST_OK;
          end
        end
      end
      default: ;
    endcase
    r.used_count = COUNT_W'(taken_total);
    return r;
  endfunction

  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] pos,
                          input logic typed, input slot_result_t typed_result);
    slot_result_t r;
    if ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_ch.valid    <= 1'b1;
    in_ch.command  <= cmd;
    in_ch.position <= pos;
    do @(posedge clk); while (!in_ch.ready);
    r = apply_command(cmd, pos);
    pending_results.push_back(typed ? typed_result : r);
  endtask

  task automatic wait_drain(input int settle);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_active_bytes(input logic [CFG_W-1:0] value);
    wait_drain(8);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    active_bytes_q = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // receiver back-pressure
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // result check on every output transfer
  always @(posedge clk) begin
    slot_result_t want;
    slot_result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {status_t'(out_ch.status), out_ch.slot, out_ch.used_count};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status %0d slot %0d count %0d", $time,
                 got.status, got.slot, got.used_count);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          $display("%0t: expected status %0d slot %0d count %0d, got %0d %0d %0d", $time,
                   want.status, want.slot, want.used_count,
                   got.status, got.slot, got.used_count);
          errors++;
        end
      end
    end
  end

  initial begin
    int phase_cfg   [NUM_PHASES];
    int phase_items [NUM_PHASES];
    int in_pct  [3];
    int out_pct [3];
    int lim;
    int hi;
    int pick;
    logic [CMD_W-1:0]  cmd;
    logic [SLOT_W-1:0] pos;

    phase_cfg   = '{128, 2, 255, 0, 16, 1, 200, 4, 0};
    phase_items = '{200, 200, 200, 40, 200, 200, 200, 200, 190};
    in_pct  = '{15, 57, 0};
    out_pct = '{57, 15, 0};

    directed_rows = '{
      '{1'b0, 8'd0,   CMD_ALLOC,  10'd0,    1'b1, '{ST_OK,      10'd0,    11'd1}},
      '{1'b0, 8'd0,   CMD_ALLOC,  10'd0,    1'b1, '{ST_OK,      10'd1,    11'd2}},
      '{1'b0, 8'd0,   CMD_MARK,   10'd5,    1'b1, '{ST_OK,      10'd5,    11'd3}},
      '{1'b0, 8'd0,   CMD_MARK,   10'd5,    1'b1, '{ST_ALREADY, 10'd5,    11'd3}},
      '{1'b0, 8'd0,   CMD_FREE,   10'd1,    1'b1, '{ST_OK,      10'd1,    11'd2}},
      '{1'b0, 8'd0,   CMD_FREE,   10'd1,    1'b1, '{ST_ALREADY, 10'd1,    11'd2}},
      '{1'b0, 8'd0,   CMD_ALLOC,  10'd0,    1'b0, '{ST_OK,      10'd0,    11'd0}},
      '{1'b0, 8'd0,   CMD_MARK,   10'd2,    1'b0, '{ST_OK,      10'd0,    11'd0}},
      '{1'b0, 8'd0,   CMD_ALLOC,  10'd0,    1'b0, '{ST_OK,      10'd0,    11'd0}},
      '{1'b0, 8'd0,   CMD_MARK,   10'd1023, 1'b0, '{ST_OK,      10'd0,    11'd0}},
      '{1'b0, 8'd0,   CMD_FREE,   10'd1023, 1'b0, '{ST_OK,      10'd0,    11'd0}},
      '{1'b0, 8'd0,   CMD_UNUSED, 10'd1023, 1'b1, '{ST_RANGE,   10'd1023, 11'd5}},
      '{1'b0, 8'd0,   CMD_UNUSED, 10'd0,    1'b1, '{ST_RANGE,   10'd0,    11'd5}},
      '{1'b1, 8'd1,   CMD_ALLOC,  10'd0,    1'b0, '{ST_OK,      10'd0,    11'd0}},
      '{1'b0, 8'd0,   CMD_MARK,   10'd8,    1'b1, '{ST_RANGE,   10'd8,    11'd5}},
      '{1'b0, 8'd0,   CMD_FREE,   10'd1023, 1'b1, '{ST_RANGE,   10'd1023, 11'd5}},
      '{1'b0, 8'd0,   CMD_ALLOC,  10'd0,    1'b0, '{ST_OK,      10'd0,    11'd0}},
      '{1'b0, 8'd0,   CMD_ALLOC,  10'd0,    1'b0, '{ST_OK,      10'd0,    11'd0}},
      '{1'b0, 8'd0,   CMD_ALLOC,  10'd0,    1'b0, '{ST_OK,      10'd0,    11'd0}},
      '{1'b0, 8'd0,   CMD_ALLOC,  10'd0,    1'b1, '{ST_FULL,    10'd0,    11'd8}},
      '{1'b1, 8'd0,   CMD_ALLOC,  10'd0,    1'b0, '{ST_OK,      10'd0,    11'd0}},
      '{1'b0, 8'd0,   CMD_ALLOC,  10'd0,    1'b1, '{ST_FULL,    10'd0,    11'd8}},
      '{1'b0, 8'd0,   CMD_FREE,   10'd0,    1'b1, '{ST_RANGE,   10'd0,    11'd8}},
      '{1'b1, 8'd255, CMD_ALLOC,  10'd0,    1'b0, '{ST_OK,      10'd0,    11'd0}},
      '{1'b0, 8'd0,   CMD_MARK,   10'd1023, 1'b0, '{ST_OK,      10'd0,    11'd0}},
      '{1'b0, 8'd0,   CMD_FREE,   10'd0,    1'b0, '{ST_OK,      10'd0,    11'd0}},
      '{1'b0, 8'd0,   CMD_ALLOC,  10'd0,    1'b0, '{ST_OK,      10'd0,    11'd0}}
    };

    errors = 0;
    taken_map = '0;
    taken_total = 0;
    lowest_free = 0;
    active_bytes_q = CFG_RESET;
    in_idle_pct = in_pct[0];
    out_idle_pct = out_pct[0];

    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_wdata      <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.command  <= CMD_ALLOC;
    in_ch.position <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[k]) begin
      if (directed_rows[k].cfg_row) begin
        set_active_bytes(directed_rows[k].cfg_value);
      end else begin
        send_cmd(directed_rows[k].cmd, directed_rows[k].pos, directed_rows[k].typed,
                 directed_rows[k].result);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      in_idle_pct  = in_pct[ph / 3];
      out_idle_pct = out_pct[ph / 3];
      set_active_bytes(ph == NUM_PHASES - 1 ? CFG_W'($urandom_range(1, 255))
                                            : CFG_W'(phase_cfg[ph]));
      for (int i = 0; i < phase_items[ph]; i++) begin
        if (ph == 4 && i == 100) wait_drain(2);
        lim  = current_limit();
        pick = $urandom_range(99);
        pos  = SLOT_W'($urandom_range(NUM_SLOTS - 1));
        if (pick < 48) begin
          cmd = CMD_ALLOC;
        end else if (pick < 94 && lim > 0 && $urandom_range(9) < 8) begin
          // aim near the hint, where the used slots pile up
          cmd = (pick < 78) ? CMD_FREE : CMD_MARK;
          hi  = (lowest_free + 8 < lim) ? lowest_free + 8 : lim - 1;
          pos = SLOT_W'($urandom_range(hi));
        end else begin
          cmd = (pick < 78) ? CMD_FREE : (pick < 94) ? CMD_MARK : CMD_UNUSED;
        end
        send_cmd(cmd, pos, 1'b0, '0);
      end
    end

    wait_drain(40);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/bsa_pkg.sv
rtl/bsa_if.sv
rtl/bsa_ram.sv
rtl/bsa_ctrl.sv
rtl/bsa_datapath.sv
rtl/bitmap_slot_allocator.sv
rtl/bsa_checker.sv
tb/testbench.sv
